// ----- design/piecewise_linear_lookup_unit_macros.svh -----
// assertion helpers shared by the lookup unit
`ifndef PIECEWISE_LINEAR_LOOKUP_UNIT_MACROS_SVH
`define PIECEWISE_LINEAR_LOOKUP_UNIT_MACROS_SVH

// a condition that must hold at every edge out of reset
`define PLK_ASSERT_ALWAYS(lbl, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// a condition that forces another one on the following edge
`define PLK_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/plk_pkg.sv -----
package plk_pkg;

    // field widths
    localparam int X_W  = 16;
    localparam int Y_W  = 16;
    localparam int QX_W = 17;

    // default table depth
    localparam int MAX_POINTS_DEF = 16;

    // 1.0 in unsigned q1.15
    localparam logic [X_W-1:0] ONE_Q15 = 16'h8000;

    // restoring divider: one quotient bit per cycle
    localparam int DIV_STEPS = 16;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    typedef enum logic [1:0] {
        KIND_APPEND = 2'd0,
        KIND_CLEAR  = 2'd1,
        KIND_QUERY  = 2'd2
    } kind_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD0,
        ST_SEG,
        ST_MUL,
        ST_DIV_INIT,
        ST_DIV,
        ST_ADD,
        ST_FIN
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic accept;
        logic load_first;
        logic seg_next;
        logic seg_take;
        logic mul;
        logic div_init;
        logic div_step;
        logic add;
        logic load_out;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic short_tbl;
        logic seg_hit;
        logic seg_zero;
        logic seg_last;
        logic out_free;
    } stat_t;

endpackage

// ----- design/piecewise_linear_lookup_unit.sv -----
// Piecewise linear lookup: a table of up to MAX_POINTS breakpoints (x unsigned
// q1.15, y signed q4.12) is built by append beats and emptied by a clear beat;
// a query beat clamps x to 0..1.0, walks the segments in order and returns
// y0 + (x - x0) * (y1 - y0) / (x1 - x0) for the first segment holding x, the
// quotient truncated toward zero, or y0 for a zero-width segment. Every input
// beat yields one result beat. Append, clear, the unused kind and a query on
// fewer than two points go from acceptance straight to the final state; a
// query on n >= 2 points loads the first breakpoint and walks the segments,
// and a hit on a nonzero-width segment is multiplied, divided and added. The
// final state loads the output register once it is free. The walk reads one
// breakpoint per cycle from a single read port, and the quotient comes from a
// restoring divider that resolves one bit per cycle. One beat is in work at a
// time; a new beat is taken while the previous result waits in the output
// register. Reset empties the table at once; breakpoint memories need no clear.
`include "piecewise_linear_lookup_unit_macros.svh"

module piecewise_linear_lookup_unit #(
    parameter int MAX_POINTS = plk_pkg::MAX_POINTS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              item_valid,
    output logic                              item_stall,
    input  logic [1:0]                        kind,
    input  logic [plk_pkg::X_W-1:0]           point_x,
    input  logic signed [plk_pkg::Y_W-1:0]    point_y,
    input  logic signed [plk_pkg::QX_W-1:0]   query_x,
    output logic                              result_valid,
    input  logic                              result_stall,
    output logic signed [plk_pkg::Y_W-1:0]    y_value,
    output logic                              found,
    output logic                              full_error
);

    plk_pkg::cmd_t  cmd;
    plk_pkg::stat_t stat;

    // sequencer
    plk_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .kind       (kind),
        .item_stall (item_stall),
        .stat       (stat),
        .cmd        (cmd)
    );

    // table, walk, multiply and divide
    plk_dpath #(
        .MAX_POINTS (MAX_POINTS)
    ) u_dpath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .kind         (kind),
        .point_x      (point_x),
        .point_y      (point_y),
        .query_x      (query_x),
        .result_stall (result_stall),
        .result_valid (result_valid),
        .y_value      (y_value),
        .found        (found),
        .full_error   (full_error)
    );

    // an accepted beat leaves the block busy on the next cycle
    `PLK_ASSERT_NEXT(a_busy_after_accept, item_valid && !item_stall, item_stall, "no busy after accept")

    // a hit and a refused append never come together
    `PLK_ASSERT_ALWAYS(a_flags_exclusive, !(result_valid && found && full_error), "found with full_error")

    // a result without a hit carries zero
    `PLK_ASSERT_ALWAYS(a_miss_zero, !(result_valid && !found) || (y_value == '0), "nonzero y on miss")

endmodule

// ----- design/plk_ram.sv -----
module plk_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // single write port, registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- design/plk_ctrl.sv -----
module plk_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_valid,
    input  logic [1:0]       kind,
    output logic             item_stall,
    input  plk_pkg::stat_t   stat,
    output plk_pkg::cmd_t    cmd
);

    plk_pkg::state_t state_reg;
    plk_pkg::state_t state_next;
    logic [plk_pkg::DIV_CNT_W-1:0] div_cnt_reg;
    logic [plk_pkg::DIV_CNT_W-1:0] div_cnt_next;

    // state and step counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= plk_pkg::ST_IDLE;
            div_cnt_reg <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            div_cnt_reg <= div_cnt_next;
        end
    end

    // one item at a time, taken only in idle
    assign item_stall = (state_reg != plk_pkg::ST_IDLE);

    // next state and commands
    always_comb
    begin
        state_next   = state_reg;
        div_cnt_next = div_cnt_reg;
        cmd          = '0;
        case (state_reg)
            plk_pkg::ST_IDLE:
            begin
                if (item_valid)
                begin
                    cmd.accept = 1'b1;
                    case (plk_pkg::kind_t'(kind))
                        plk_pkg::KIND_QUERY:
                        begin
                            state_next = stat.short_tbl ? plk_pkg::ST_FIN : plk_pkg::ST_LOAD0;
                        end
                        default:
                        begin
                            state_next = plk_pkg::ST_FIN;
                        end
                    endcase
                end
            end
            plk_pkg::ST_LOAD0:
            begin
                cmd.load_first = 1'b1;
                state_next     = plk_pkg::ST_SEG;
            end
            plk_pkg::ST_SEG:
            begin
                if (stat.seg_hit)
                begin
                    cmd.seg_take = 1'b1;
                    state_next   = stat.seg_zero ? plk_pkg::ST_FIN : plk_pkg::ST_MUL;
                end
                else
                begin
                    cmd.seg_next = 1'b1;
                    state_next   = stat.seg_last ? plk_pkg::ST_FIN : plk_pkg::ST_SEG;
                end
            end
            plk_pkg::ST_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = plk_pkg::ST_DIV_INIT;
            end
            plk_pkg::ST_DIV_INIT:
            begin
                cmd.div_init = 1'b1;
                div_cnt_next = '0;
                state_next   = plk_pkg::ST_DIV;
            end
            plk_pkg::ST_DIV:
            begin
                cmd.div_step = 1'b1;
                div_cnt_next = div_cnt_reg + 1'b1;
                if (div_cnt_reg == plk_pkg::DIV_CNT_W'(plk_pkg::DIV_STEPS - 1))
                begin
                    state_next = plk_pkg::ST_ADD;
                end
            end
            plk_pkg::ST_ADD:
            begin
                cmd.add    = 1'b1;
                state_next = plk_pkg::ST_FIN;
            end
            plk_pkg::ST_FIN:
            begin
                if (stat.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = plk_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = plk_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// ----- design/plk_dpath.sv -----
module plk_dpath #(
    parameter int MAX_POINTS = plk_pkg::MAX_POINTS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  plk_pkg::cmd_t                     cmd,
    output plk_pkg::stat_t                    stat,
    input  logic [1:0]                        kind,
    input  logic [plk_pkg::X_W-1:0]           point_x,
    input  logic signed [plk_pkg::Y_W-1:0]    point_y,
    input  logic signed [plk_pkg::QX_W-1:0]   query_x,
    input  logic                              result_stall,
    output logic                              result_valid,
    output logic signed [plk_pkg::Y_W-1:0]    y_value,
    output logic                              found,
    output logic                              full_error
);

    localparam int IW = $clog2(MAX_POINTS);
    localparam int CW = $clog2(MAX_POINTS + 1);
    localparam int XW = plk_pkg::X_W;
    localparam int YW = plk_pkg::Y_W;

    // control registers
    logic [CW-1:0] cnt_reg;
    logic          out_valid_reg;

    // payload registers
    logic [IW-1:0]          idx_reg;
    logic [XW-1:0]          qx_reg;
    logic [XW-1:0]          prev_x_reg;
    logic signed [YW-1:0]   prev_y_reg;
    logic [XW-1:0]          dx_reg;
    logic signed [YW:0]     dy_reg;
    logic [XW-1:0]          den_reg;
    logic signed [2*YW+1:0] prod_reg;
    logic [XW-1:0]          rem_reg;
    logic [XW-1:0]          low_reg;
    logic                   neg_reg;
    logic signed [YW-1:0]   res_y_reg;
    logic                   res_found_reg;
    logic                   res_full_reg;
    logic signed [YW-1:0]   out_y_reg;
    logic                   out_found_reg;
    logic                   out_full_reg;

    // memory ports
    logic                   wr_en;
    logic [IW-1:0]          raddr;
    logic [XW-1:0]          cur_x;
    logic [YW-1:0]          cur_y;

    // combinational helpers
    logic                   is_append;
    logic                   is_clear;
    logic                   tbl_full;
    logic [XW-1:0]          qx_clamp;
    logic signed [2*YW+1:0] prod_full;
    logic [2*YW+1:0]        prod_mag;
    logic [XW:0]            div_trial;
    logic [XW:0]            div_diff;
    logic                   div_ge;
    logic signed [YW+1:0]   quot_s;
    logic signed [YW+1:0]   y_sum;

    // item decode
    assign is_append = (kind == plk_pkg::KIND_APPEND);
    assign is_clear  = (kind == plk_pkg::KIND_CLEAR);
    assign tbl_full  = (cnt_reg == CW'(MAX_POINTS));
    assign wr_en     = cmd.accept && is_append && !tbl_full;

    // clamp query x to 0..1.0
    always_comb
    begin
        if (query_x[plk_pkg::QX_W-1])
        begin
            qx_clamp = '0;
        end
        else if (query_x[XW-1:0] > plk_pkg::ONE_Q15)
        begin
            qx_clamp = plk_pkg::ONE_Q15;
        end
        else
        begin
            qx_clamp = query_x[XW-1:0];
        end
    end

    // read address for the segment walk
    always_comb
    begin
        if (cmd.load_first)
        begin
            raddr = idx_reg;
        end
        else if (cmd.seg_next)
        begin
            raddr = idx_reg + 1'b1;
        end
        else
        begin
            raddr = '0;
        end
    end

    plk_ram #(
        .WIDTH (XW),
        .DEPTH (MAX_POINTS)
    ) u_x_ram (
        .clk   (clk),
        .we    (wr_en),
        .waddr (cnt_reg[IW-1:0]),
        .wdata (point_x),
        .raddr (raddr),
        .rdata (cur_x)
    );

    plk_ram #(
        .WIDTH (YW),
        .DEPTH (MAX_POINTS)
    ) u_y_ram (
        .clk   (clk),
        .we    (wr_en),
        .waddr (cnt_reg[IW-1:0]),
        .wdata (point_y),
        .raddr (raddr),
        .rdata (cur_y)
    );

    // segment checks against the entry just read
    assign stat.short_tbl = (cnt_reg < CW'(2));
    assign stat.seg_hit   = (qx_reg >= prev_x_reg) && (qx_reg <= cur_x);
    assign stat.seg_zero  = (cur_x == prev_x_reg);
    assign stat.seg_last  = ((CW'(idx_reg) + CW'(1)) == cnt_reg);
    assign stat.out_free  = !out_valid_reg || !result_stall;

    // product, magnitude and one divider step
    assign prod_full = $signed({1'b0, dx_reg}) * dy_reg;
    assign prod_mag  = prod_reg[2*YW+1] ? (2*YW+2)'(-prod_reg) : prod_reg;
    assign div_trial = {rem_reg, low_reg[XW-1]};
    assign div_diff  = div_trial - {1'b0, den_reg};
    assign div_ge    = (div_trial >= {1'b0, den_reg});
    assign quot_s    = neg_reg ? -$signed({2'b00, low_reg}) : $signed({2'b00, low_reg});
    assign y_sum     = $signed({{2{prev_y_reg[YW-1]}}, prev_y_reg}) + quot_s;

    // point count and output handshake
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (cmd.accept && is_clear)
            begin
                cnt_reg <= '0;
            end

            if (cmd.load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !result_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // walk, multiply, divide and result registers
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            qx_reg        <= qx_clamp;
            idx_reg       <= IW'(1);
            res_y_reg     <= '0;
            res_found_reg <= 1'b0;
            res_full_reg  <= is_append && tbl_full;
        end
        if (cmd.load_first || cmd.seg_next)
        begin
            prev_x_reg <= cur_x;
            prev_y_reg <= $signed(cur_y);
        end
        if (cmd.seg_next)
        begin
            idx_reg <= idx_reg + 1'b1;
        end
        if (cmd.seg_take)
        begin
            dx_reg        <= qx_reg - prev_x_reg;
            dy_reg        <= $signed({cur_y[YW-1], cur_y}) - $signed({prev_y_reg[YW-1], prev_y_reg});
            den_reg       <= cur_x - prev_x_reg;
            res_y_reg     <= prev_y_reg;
            res_found_reg <= 1'b1;
        end
        if (cmd.mul)
        begin
            prod_reg <= prod_full;
        end
        if (cmd.div_init)
        begin
            neg_reg <= prod_reg[2*YW+1];
            rem_reg <= prod_mag[2*XW-1:XW];
            low_reg <= prod_mag[XW-1:0];
        end
        if (cmd.div_step)
        begin
            rem_reg <= div_ge ? div_diff[XW-1:0] : div_trial[XW-1:0];
            low_reg <= {low_reg[XW-2:0], div_ge};
        end
        if (cmd.add)
        begin
            res_y_reg <= y_sum[YW-1:0];
        end
        if (cmd.load_out)
        begin
            out_y_reg     <= res_y_reg;
            out_found_reg <= res_found_reg;
            out_full_reg  <= res_full_reg;
        end
    end

    assign result_valid = out_valid_reg;
    assign y_value      = out_y_reg;
    assign found        = out_found_reg;
    assign full_error   = out_full_reg;

endmodule
